[design/fire_spread_grid_step_unit_assert.svh]
// Assertion macros shared by the checker of the fire grid unit
`ifndef FIRE_SPREAD_GRID_STEP_UNIT_ASSERT_SVH
`define FIRE_SPREAD_GRID_STEP_UNIT_ASSERT_SVH
// same-cycle implication
`define FSGS_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// next-cycle implication
`define FSGS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

[design/fsgs_pkg.sv]
// Shared constants, types and helpers of the fire grid unit
`default_nettype none
package fsgs_pkg;
	localparam int GRID_SIDE = 32;
	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int POS_W = $clog2(GRID_SIDE);
	localparam int ISS_LAST = CELLS + GRID_SIDE - 1;
	localparam int ISS_W = $clog2(CELLS + GRID_SIDE + 1);
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int OUT_CNT_W = 11;
	localparam int COUNT_MAX = 2047;
	localparam int FIELD_POS_W = 5;
	localparam int THR_W = 11;
	localparam int SEED_W = 16;
	localparam logic [THR_W-1:0] THR_RESET = 11'd512;
	localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;
	localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

	localparam logic [1:0] CELL_EMPTY = 2'd0;
	localparam logic [1:0] CELL_TREE = 2'd1;
	localparam logic [1:0] CELL_FIRE = 2'd2;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_STEP = 2'd2;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_SEED = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WR_RD,
		ST_WR_UP,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [1:0] center;
		logic [1:0] up;
		logic [1:0] down;
		logic [1:0] left_n;
		logic [1:0] right_n;
	} nbr_t;

	function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
		if (32'(c) > COUNT_MAX)
			return OUT_CNT_W'(COUNT_MAX);
		return OUT_CNT_W'(c);
	endfunction
endpackage
`default_nettype wire

[design/fire_spread_grid_step_unit.sv]
// Forest fire grid unit. Requests on s_*: tuser is the kind (write cell, read cell,
// step one generation), tdata the cell address and value; each request gives one
// result on m_* with the read value and the burning-cell count. A read passes
// through ST_RD and ST_DONE, a write through ST_WR_RD, ST_WR_UP and ST_DONE;
// a generation step streams the grid through the one read port of the cell
// memory one cell per cycle behind a two-row line buffer. After reset a
// clearing pass loads the start grid before the first request is taken;
// configuration writes are taken at any time.
`default_nettype none
module fire_spread_grid_step_unit import fsgs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [15:0] s_tdata,   // row[4:0], col[9:5], cell_value[11:10], zeros
	input wire logic [1:0] s_tuser,    // kind[1:0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata,       // read_value[1:0], burning_count[12:2], zeros
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	state_t state_q, state_d;
	mem_req_t req;
	logic [1:0] rdata;
	logic init_busy;
	nbr_t nbr;

	logic [1:0] kind_q, val_q;
	logic [FIELD_POS_W-1:0] row_q, col_q;
	logic in_grid;
	logic [ADDR_W-1:0] item_addr;

	logic [THR_W-1:0] thr_q;
	logic [SEED_W-1:0] lfsr_q, lfsr_nx;
	logic [CNT_W-1:0] cnt_q, step_cnt_q, step_cnt_nx;

	logic [ISS_W-1:0] iss_q;
	logic iss_v;
	logic shift_v_s1, shift_grid_s1, shift_ctr_s1, shift_last_s1;
	logic proc_v_s2, proc_ctr_s2, proc_last_s2;
	logic [POS_W-1:0] crow_q, ccol_q;
	logic [ADDR_W-1:0] caddr_q;

	logic near_fire, fire_try, ignite, proc_do;
	logic [1:0] new_val;
	logic accept, out_load;

	fsgs_cell_store u_store (
		.clk(clk), .arst_n(arst_n), .req(req), .rdata(rdata), .init_busy(init_busy)
	);

	fsgs_window u_window (
		.clk(clk), .shift_en(shift_v_s1),
		.shift_in(shift_grid_s1 ? rdata : CELL_EMPTY), .nbr(nbr)
	);

	assign s_tready = (state_q == ST_IDLE) && !init_busy;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign in_grid = 32'(row_q) < GRID_SIDE && 32'(col_q) < GRID_SIDE;
	assign item_addr = ADDR_W'(32'(row_q) * GRID_SIDE + 32'(col_q));
	assign iss_v = 32'(iss_q) <= ISS_LAST;

	// cell rule on the center of the line buffer
	assign near_fire = (nbr.up == CELL_FIRE && crow_q != '0) ||
		(nbr.down == CELL_FIRE && 32'(crow_q) != GRID_SIDE - 1) ||
		(nbr.left_n == CELL_FIRE && ccol_q != '0) ||
		(nbr.right_n == CELL_FIRE && 32'(ccol_q) != GRID_SIDE - 1);
	assign proc_do = proc_v_s2 && proc_ctr_s2;
	assign fire_try = proc_do && nbr.center == CELL_TREE && near_fire;
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
	assign ignite = fire_try && {1'b0, lfsr_nx[9:0]} < thr_q;
	assign new_val = ignite ? CELL_FIRE :
		(nbr.center == CELL_FIRE ? CELL_EMPTY : nbr.center);
	assign step_cnt_nx = step_cnt_q + CNT_W'(new_val == CELL_FIRE);
	assign out_load = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	always_comb begin
		state_d = state_q;
		req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						KIND_WRITE: state_d = ST_WR_RD;
						KIND_READ: state_d = ST_RD;
						KIND_STEP: state_d = ST_STEP;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_RD: begin
				req.rd_en = in_grid;
				req.rd_addr = item_addr;
				state_d = ST_DONE;
			end
			ST_WR_RD: begin
				req.rd_en = in_grid;
				req.rd_addr = item_addr;
				state_d = ST_WR_UP;
			end
			ST_WR_UP: begin
				req.wr_en = in_grid;
				req.wr_addr = item_addr;
				req.wr_data = val_q;
				state_d = ST_DONE;
			end
			ST_STEP: begin
				req.rd_en = 32'(iss_q) < CELLS;
				req.rd_addr = iss_q[ADDR_W-1:0];
				req.wr_en = proc_do;
				req.wr_addr = caddr_q;
				req.wr_data = new_val;
				if (proc_v_s2 && proc_last_s2)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			row_q <= s_tdata[4:0];
			col_q <= s_tdata[9:5];
			val_q <= s_tdata[11:10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			lfsr_q <= SEED_RESET;
			cnt_q <= '0;
			step_cnt_q <= '0;
			iss_q <= '0;
			shift_v_s1 <= 1'b0;
			shift_grid_s1 <= 1'b0;
			shift_ctr_s1 <= 1'b0;
			shift_last_s1 <= 1'b0;
			proc_v_s2 <= 1'b0;
			proc_ctr_s2 <= 1'b0;
			proc_last_s2 <= 1'b0;
			crow_q <= '0;
			ccol_q <= '0;
			caddr_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					REG_SEED: lfsr_q <= (cfg_data == '0) ? SEED_RESET : cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				iss_q <= '0;
				step_cnt_q <= '0;
				crow_q <= '0;
				ccol_q <= '0;
				caddr_q <= '0;
			end else if (state_q == ST_STEP && iss_v) begin
				iss_q <= iss_q + 1'b1;
			end
			shift_v_s1 <= state_q == ST_STEP && iss_v;
			shift_grid_s1 <= 32'(iss_q) < CELLS;
			shift_ctr_s1 <= 32'(iss_q) >= GRID_SIDE;
			shift_last_s1 <= 32'(iss_q) == ISS_LAST;
			proc_v_s2 <= shift_v_s1;
			proc_ctr_s2 <= shift_ctr_s1;
			proc_last_s2 <= shift_last_s1;
			if (proc_do) begin
				step_cnt_q <= step_cnt_nx;
				caddr_q <= caddr_q + 1'b1;
				if (32'(ccol_q) == GRID_SIDE - 1) begin
					ccol_q <= '0;
					crow_q <= crow_q + 1'b1;
				end else begin
					ccol_q <= ccol_q + 1'b1;
				end
				if (proc_last_s2)
					cnt_q <= step_cnt_nx;
			end
			if (fire_try)
				lfsr_q <= lfsr_nx;
			if (state_q == ST_WR_UP && in_grid)
				cnt_q <= cnt_q + CNT_W'(val_q == CELL_FIRE) - CNT_W'(rdata == CELL_FIRE);
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata <= {3'b000, sat_count(cnt_q),
					(kind_q == KIND_READ && in_grid) ? rdata : CELL_EMPTY};
			end
		end
	end
endmodule
`default_nettype wire

[design/fsgs_cell_store.sv]
// Cell grid memory with its clearing pass after reset
`default_nettype none
module fsgs_cell_store import fsgs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire mem_req_t req,
	output logic [1:0] rdata,
	output logic init_busy
);
	logic [1:0] mem [CELLS];
	logic busy_q;
	logic [POS_W-1:0] irow_q, icol_q;
	logic [ADDR_W-1:0] iaddr_q;
	logic [1:0] init_val;
	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [1:0] wdata;

	assign init_busy = busy_q;
	assign init_val = (32'(irow_q) == 0 || 32'(icol_q) == 0 ||
		32'(irow_q) == GRID_SIDE - 1 || 32'(icol_q) == GRID_SIDE - 1) ? CELL_EMPTY : CELL_TREE;
	assign we = busy_q ? 1'b1 : req.wr_en;
	assign waddr = busy_q ? iaddr_q : req.wr_addr;
	assign wdata = busy_q ? init_val : req.wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			irow_q <= '0;
			icol_q <= '0;
			iaddr_q <= '0;
		end else if (busy_q) begin
			iaddr_q <= iaddr_q + 1'b1;
			if (32'(icol_q) == GRID_SIDE - 1) begin
				icol_q <= '0;
				irow_q <= irow_q + 1'b1;
				if (32'(irow_q) == GRID_SIDE - 1)
					busy_q <= 1'b0;
			end else begin
				icol_q <= icol_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (req.rd_en && !busy_q)
			rdata <= mem[req.rd_addr];
	end
endmodule
`default_nettype wire

[design/fsgs_window.sv]
// Two-row line buffer giving a cell and its four neighbors
`default_nettype none
module fsgs_window import fsgs_pkg::*; (
	input wire logic clk,
	input wire logic shift_en,
	input wire logic [1:0] shift_in,
	output nbr_t nbr
);
	logic [1:0] taps_q [2*GRID_SIDE+1];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			taps_q[0] <= shift_in;
			for (int i = 1; i < 2*GRID_SIDE+1; i++)
				taps_q[i] <= taps_q[i-1];
		end
	end

	// newest tap is the cell one row below the center
	assign nbr.down = taps_q[0];
	assign nbr.right_n = taps_q[GRID_SIDE-1];
	assign nbr.center = taps_q[GRID_SIDE];
	assign nbr.left_n = taps_q[GRID_SIDE+1];
	assign nbr.up = taps_q[2*GRID_SIDE];
endmodule
`default_nettype wire

[design/fsgs_checker.sv]
// Port-level checker of the fire grid unit and its bind
`default_nettype none
`include "fire_spread_grid_step_unit_assert.svh"
module fsgs_checker import fsgs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [15:0] m_tdata
);
	`FSGS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`FSGS_ASSERT_NOW(a_count_range, clk, arst_n, m_tvalid, 32'(m_tdata[12:2]) <= CELLS)
	`FSGS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`FSGS_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[15:13] == 3'b000)
endmodule

bind fire_spread_grid_step_unit fsgs_checker u_fsgs_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
